>>> src/lds_pkg.sv
package lds_pkg;

    // Largest frame dimension; larger register values are clamped to it.
    localparam int MAX_DIM = 4096;

    localparam int DIM_W   = 13;   // frame_width / frame_height
    localparam int COORD_W = 12;   // pixel coordinates
    localparam int CURV_W  = 16;
    localparam int SHIFT_W = 17;
    localparam int INV_W   = 48;
    localparam int RGBA_W  = 32;

    localparam int APB_AW  = 6;
    localparam int APB_DW  = 64;

    // Datapath widths
    localparam int D2_W    = 14;   // doubled centered coordinate, signed
    localparam int SQ_W    = 27;
    localparam int SUM_W   = 28;
    localparam int INV_LO_W = 16;
    localparam int INV_HI_W = INV_W - INV_LO_W;
    localparam int PHI_W   = SUM_W + INV_HI_W;
    localparam int PLO_W   = SUM_W + INV_LO_W;
    localparam int R2F_W   = PHI_W + 1;
    localparam int R2_W    = 36;   // unsigned Q32, saturated below 16.0
    localparam int PROD_W  = CURV_W + R2_W + 1;
    localparam int CK_SH   = 15;
    localparam int K_W     = PROD_W - CK_SH;
    localparam int SH_W    = SHIFT_W + R2_W + 1;
    localparam int M_W     = D2_W + K_W;
    localparam int S_W     = 58;   // twice the source coordinate, Q36
    localparam int S_FRAC  = 36;
    localparam int Q_W     = S_W - S_FRAC - 1;

    localparam logic [R2_W-1:0] R2_MAX = {R2_W{1'b1}};
    localparam logic [K_W-1:0]  K_ONE  = K_W'(64'd1 << 32);
    localparam logic [S_W-1:0]  ROUND_HALF = S_W'(64'd1 << S_FRAC);

    localparam int NUM_STAGES = 12;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_CURVATURE     = 3'd2,
        REG_HORIZ_SHIFT   = 3'd3,
        REG_VERT_SHIFT    = 3'd4,
        REG_INV_DIAG_SQ   = 3'd5,
        REG_FILL_RGBA     = 3'd6
    } reg_index_t;

    localparam logic [DIM_W-1:0]  FRAME_DIM_RST = DIM_W'(1024);
    localparam logic [INV_W-1:0]  INV_DIAG_RST  = INV_W'(64'd1 << 27);
    localparam logic [RGBA_W-1:0] FILL_RST      = RGBA_W'(255);

endpackage

>>> src/lens_distortion_source_address.sv
// Lens distortion source address generator.
// Input channel (in_valid/in_ready): one output pixel coordinate (out_x, out_y)
// per transaction. Output channel (out_valid/out_ready): the nearest source
// pixel (src_x, src_y), inside_res, and fill_value (fill color when the source
// falls outside the frame, zero otherwise). One result per input, in order.
// Configuration goes through the APB port, 64-bit data, register i at byte
// address 8*i; write only while no transaction is in flight. pready is tied high.
// Throughput: one transaction per clock while out_ready is high. The pipeline
// has 12 register stages; the stage count is set by the r2 product (split into
// two partial products), the curvature product, the per-axis k product and the
// rounding. Each stage holds while its successor is full and stalled, so an
// out_ready stall fills the bubbles first and only then drops in_ready.
// Reset clears all stage valid bits and loads the register defaults
// (1024 x 1024 frame, no distortion, fill 0x000000FF).
module lens_distortion_source_address
    import lds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_W-1:0]    out_x,
    input  logic [COORD_W-1:0]    out_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_W-1:0]    src_x,
    output logic [COORD_W-1:0]    src_y,
    output logic                  inside_res,
    output logic [RGBA_W-1:0]     fill_value
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]          frame_width_reg;
    logic [DIM_W-1:0]          frame_height_reg;
    logic signed [CURV_W-1:0]  curvature_reg;
    logic signed [SHIFT_W-1:0] horizontal_shift_reg;
    logic signed [SHIFT_W-1:0] vertical_shift_reg;
    logic [INV_W-1:0]          inverse_diagonal_sq_reg;
    logic [RGBA_W-1:0]         fill_rgba_reg;

    reg_index_t                reg_idx;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[APB_AW-1:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg         <= FRAME_DIM_RST;
            frame_height_reg        <= FRAME_DIM_RST;
            curvature_reg           <= '0;
            horizontal_shift_reg    <= '0;
            vertical_shift_reg      <= '0;
            inverse_diagonal_sq_reg <= INV_DIAG_RST;
            fill_rgba_reg           <= FILL_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg         <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg        <= pwdata[DIM_W-1:0];
                REG_CURVATURE:    curvature_reg           <= signed'(pwdata[CURV_W-1:0]);
                REG_HORIZ_SHIFT:  horizontal_shift_reg    <= signed'(pwdata[SHIFT_W-1:0]);
                REG_VERT_SHIFT:   vertical_shift_reg      <= signed'(pwdata[SHIFT_W-1:0]);
                REG_INV_DIAG_SQ:  inverse_diagonal_sq_reg <= pwdata[INV_W-1:0];
                REG_FILL_RGBA:    fill_rgba_reg           <= pwdata[RGBA_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            REG_CURVATURE:    prdata = APB_DW'(unsigned'(curvature_reg));
            REG_HORIZ_SHIFT:  prdata = APB_DW'(unsigned'(horizontal_shift_reg));
            REG_VERT_SHIFT:   prdata = APB_DW'(unsigned'(vertical_shift_reg));
            REG_INV_DIAG_SQ:  prdata = APB_DW'(inverse_diagonal_sq_reg);
            REG_FILL_RGBA:    prdata = APB_DW'(fill_rgba_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamped frame dimensions
    logic [DIM_W-1:0] width_c;
    logic [DIM_W-1:0] height_c;

    assign width_c  = (frame_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width_reg;
    assign height_c = (frame_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_reg;

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    // stage 0: doubled centered coordinates
    logic signed [D2_W-1:0]  dx2_0_reg, dy2_0_reg, dx2_0_next, dy2_0_next;
    // stage 1: squares
    logic signed [2*D2_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic signed [D2_W-1:0]  dx2_1_reg, dy2_1_reg;
    // stage 2: sum of squares
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [D2_W-1:0]  dx2_2_reg, dy2_2_reg;
    // stage 3: partial products of sum * inverse
    logic [PHI_W-1:0]        phi_reg, phi_next;
    logic [PLO_W-1:0]        plo_reg, plo_next;
    logic signed [D2_W-1:0]  dx2_3_reg, dy2_3_reg;
    // stage 4: saturated r2
    logic [R2F_W-1:0]        r2_full;
    logic [R2_W-1:0]         r2_reg, r2_next;
    logic signed [D2_W-1:0]  dx2_4_reg, dy2_4_reg;
    // stage 5: curvature and shift products
    logic signed [R2_W:0]    r2_s;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SH_W-1:0]  shx_5_reg, shy_5_reg, shx_5_next, shy_5_next;
    logic signed [D2_W-1:0]  dx2_5_reg, dy2_5_reg;
    // stage 6: k
    logic signed [K_W-1:0]   k_reg, k_next;
    logic signed [SH_W-1:0]  shx_6_reg, shy_6_reg;
    logic signed [D2_W-1:0]  dx2_6_reg, dy2_6_reg;
    // stage 7: d2 * k
    logic signed [M_W-1:0]   mx_reg, my_reg, mx_next, my_next;
    logic signed [SH_W-1:0]  shx_7_reg, shy_7_reg;
    // stage 8: twice the source coordinate, Q36
    logic [S_W-1:0]          sx_reg, sy_reg, sx_next, sy_next;
    // stage 9: sign and magnitude
    logic                    negx_9_reg, negy_9_reg;
    logic [S_W-1:0]          magx_reg, magy_reg, magx_next, magy_next;
    // stage 10: rounded magnitude
    logic                    negx_10_reg, negy_10_reg;
    logic [S_W-1:0]          rndx, rndy;
    logic [Q_W-1:0]          qx_reg, qy_reg, qx_next, qy_next;
    // stage 11: output
    logic                    in_x, in_y, inside_next;
    logic [COORD_W-1:0]      src_x_reg, src_y_reg, src_x_next, src_y_next;
    logic                    inside_reg;
    logic [RGBA_W-1:0]       fill_value_reg, fill_value_next;

    always_comb
    begin
        dx2_0_next = signed'({1'b0, out_x, 1'b0}) - signed'({1'b0, width_c});
        dy2_0_next = signed'({1'b0, out_y, 1'b0}) - signed'({1'b0, height_c});

        // full-width signed squares; the result is never negative
        sqx_full = dx2_0_reg * dx2_0_reg;
        sqy_full = dy2_0_reg * dy2_0_reg;
        sqx_next = sqx_full[SQ_W-1:0];
        sqy_next = sqy_full[SQ_W-1:0];

        sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

        phi_next = PHI_W'(sum_reg) * PHI_W'(inverse_diagonal_sq_reg[INV_W-1:INV_LO_W]);
        plo_next = PLO_W'(sum_reg) * PLO_W'(inverse_diagonal_sq_reg[INV_LO_W-1:0]);

        // floor(sum * inv / 2^16), saturated
        r2_full = {1'b0, phi_reg} + R2F_W'(plo_reg[PLO_W-1:INV_LO_W]);
        r2_next = (r2_full[R2F_W-1:R2_W] != '0) ? R2_MAX : r2_full[R2_W-1:0];

        r2_s       = signed'({1'b0, r2_reg});
        prod_next  = PROD_W'(curvature_reg) * PROD_W'(r2_s);
        shx_5_next = SH_W'(horizontal_shift_reg) * SH_W'(r2_s);
        shy_5_next = SH_W'(vertical_shift_reg) * SH_W'(r2_s);

        // floor(c * r2 / 2^15) + 1.0
        k_next = signed'(prod_reg[PROD_W-1:CK_SH]) + signed'(K_ONE);

        mx_next = M_W'(dx2_6_reg) * M_W'(k_reg);
        my_next = M_W'(dy2_6_reg) * M_W'(k_reg);

        sx_next = {{(S_W-DIM_W-S_FRAC){1'b0}}, width_c, {S_FRAC{1'b0}}}
                + {{(S_W-M_W-4){mx_reg[M_W-1]}}, mx_reg, 4'b0}
                + {{(S_W-SH_W-1){shx_7_reg[SH_W-1]}}, shx_7_reg, 1'b0};
        sy_next = {{(S_W-DIM_W-S_FRAC){1'b0}}, height_c, {S_FRAC{1'b0}}}
                + {{(S_W-M_W-4){my_reg[M_W-1]}}, my_reg, 4'b0}
                + {{(S_W-SH_W-1){shy_7_reg[SH_W-1]}}, shy_7_reg, 1'b0};

        magx_next = sx_reg[S_W-1] ? (~sx_reg + S_W'(1)) : sx_reg;
        magy_next = sy_reg[S_W-1] ? (~sy_reg + S_W'(1)) : sy_reg;

        // round half away from zero on the magnitude
        rndx    = magx_reg + ROUND_HALF;
        rndy    = magy_reg + ROUND_HALF;
        qx_next = rndx[S_W-1:S_FRAC+1];
        qy_next = rndy[S_W-1:S_FRAC+1];

        // a negative value that rounds to zero still counts as zero
        in_x = (!negx_10_reg || (qx_reg == '0)) && (qx_reg < Q_W'(width_c));
        in_y = (!negy_10_reg || (qy_reg == '0)) && (qy_reg < Q_W'(height_c));
        inside_next     = in_x && in_y;
        src_x_next      = inside_next ? qx_reg[COORD_W-1:0] : '0;
        src_y_next      = inside_next ? qy_reg[COORD_W-1:0] : '0;
        fill_value_next = inside_next ? '0 : fill_rgba_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx2_0_reg <= dx2_0_next;
            dy2_0_reg <= dy2_0_next;
        end
        if (en[1])
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            dx2_1_reg <= dx2_0_reg;
            dy2_1_reg <= dy2_0_reg;
        end
        if (en[2])
        begin
            sum_reg   <= sum_next;
            dx2_2_reg <= dx2_1_reg;
            dy2_2_reg <= dy2_1_reg;
        end
        if (en[3])
        begin
            phi_reg   <= phi_next;
            plo_reg   <= plo_next;
            dx2_3_reg <= dx2_2_reg;
            dy2_3_reg <= dy2_2_reg;
        end
        if (en[4])
        begin
            r2_reg    <= r2_next;
            dx2_4_reg <= dx2_3_reg;
            dy2_4_reg <= dy2_3_reg;
        end
        if (en[5])
        begin
            prod_reg  <= prod_next;
            shx_5_reg <= shx_5_next;
            shy_5_reg <= shy_5_next;
            dx2_5_reg <= dx2_4_reg;
            dy2_5_reg <= dy2_4_reg;
        end
        if (en[6])
        begin
            k_reg     <= k_next;
            shx_6_reg <= shx_5_reg;
            shy_6_reg <= shy_5_reg;
            dx2_6_reg <= dx2_5_reg;
            dy2_6_reg <= dy2_5_reg;
        end
        if (en[7])
        begin
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            shx_7_reg <= shx_6_reg;
            shy_7_reg <= shy_6_reg;
        end
        if (en[8])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (en[9])
        begin
            negx_9_reg <= sx_reg[S_W-1];
            negy_9_reg <= sy_reg[S_W-1];
            magx_reg   <= magx_next;
            magy_reg   <= magy_next;
        end
        if (en[10])
        begin
            negx_10_reg <= negx_9_reg;
            negy_10_reg <= negy_9_reg;
            qx_reg      <= qx_next;
            qy_reg      <= qy_next;
        end
        if (en[11])
        begin
            src_x_reg      <= src_x_next;
            src_y_reg      <= src_y_next;
            inside_reg     <= inside_next;
            fill_value_reg <= fill_value_next;
        end
    end

    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign inside_res = inside_reg;
    assign fill_value = fill_value_reg;

`ifndef ASSERT_OFF
    // an output that is being drained always frees the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    a_inside_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |->
            fill_value == '0 && COORD_W'(src_x) < width_c && COORD_W'(src_y) < height_c)
        else $error("inside result with bad fields");

    a_outside_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |->
            src_x == '0 && src_y == '0 && fill_value == fill_rgba_reg)
        else $error("outside result with bad fields");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NUM_STAGES-2] && en[NUM_STAGES-1] |=> out_valid)
        else $error("result lost entering output stage");
`endif

endmodule
